// ===== rtl/cjgt_pkg.sv =====
// Shared types, constants and tables for the civil/Julian/GPS time converter.
package cjgt_pkg;

   // Fraction of a second, fixed point
   localparam int FRAC_BITS = 20;

   // Input form codes
   typedef enum logic [1:0] {
      OP_CIVIL       = 2'd0,
      OP_JULIAN      = 2'd1,
      OP_GPS_WEEK    = 2'd2,
      OP_DAY_OF_YEAR = 2'd3
   } op_type;

   // Day and time constants
   localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
   localparam logic [16:0] HALF_DAY      = 17'd43200;
   localparam logic [22:0] CAL_OFFSET    = 23'd1720981;
   localparam logic [22:0] GPS_EPOCH_DAY = 23'd2444244;
   // CAL_OFFSET plus January term (month 13 -> 428) plus day 1
   localparam logic [26:0] JAN_FIRST_OFFSET = 27'd1721410;
   // Shift from day a to the positive week numerator: a - 1 - epoch + 7 * 2^19
   localparam logic [22:0] WEEK_BIAS     = 23'd1225771;

   // Reciprocals for exact floor division by constants
   localparam logic [14:0] RECIP_675 = 15'((64'd1 << 24) / 64'd675 + 64'd1);
   localparam logic [29:0] RECIP_C   = 30'((64'd1 << 45) / 64'd36525 + 64'd1);
   localparam logic [23:0] RECIP_7   = 24'((64'd1 << 26) / 64'd7 + 64'd1);
   localparam logic [17:0] RECIP_60  = 18'((64'd1 << 23) / 64'd60 + 64'd1);
   localparam logic [11:0] RECIP_60S = 12'((64'd1 << 17) / 64'd60 + 64'd1);

   // floor(30.6001 * k)
   localparam logic [8:0] MONTH_TERM [17] = '{
      9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214, 9'd244,
      9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459, 9'd489
   };

   // ceil(30.6001 * k); entry zero unused
   localparam logic [8:0] MONTH_LIMIT [17] = '{
      9'd0,   9'd31,  9'd62,  9'd92,  9'd123, 9'd154, 9'd184, 9'd215, 9'd245,
      9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460, 9'd490
   };

   // Calendar and clock fields handed from the back end to the top level
   typedef struct packed {
      logic [3:0]         month;
      logic [4:0]         day_of_month;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
      logic [22:0]        julian_day;
      logic [16:0]        day_seconds;
      logic [13:0]        gps_week;
      logic [19:0]        week_second;
      logic signed [14:0] civil_year;
      logic [22:0]        day_a;
   } result_type;

endpackage

// ===== rtl/cjgt_front.sv =====
// Front end: reduce any input form to Julian day and seconds since noon.
module cjgt_front #(
   parameter int FRAC_BITS = cjgt_pkg::FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  cjgt_pkg::op_type              op,
   input  logic [11:0]                   year,
   input  logic [3:0]                    month,
   input  logic [8:0]                    day_number,
   input  logic [4:0]                    hour,
   input  logic [5:0]                    minute,
   input  logic [5:0]                    whole_second,
   input  logic [FRAC_BITS-1:0]          second_fraction,
   input  logic [21:0]                   julian_day,
   input  logic [16:0]                   day_seconds,
   input  logic [13:0]                   gps_week,
   input  logic [19:0]                   week_second,
   output logic                          out_valid,
   output logic [22:0]                   out_jd,
   output logic [16:0]                   out_ds,
   output logic [FRAC_BITS-1:0]          out_frac
);
   import cjgt_pkg::*;

   logic [11:0] wide_year;
   logic [11:0] yy_in;
   logic [4:0]  idx;
   logic [17:0] tod;
   logic [17:0] tod_sub;
   logic        carry_in;
   logic [16:0] sec_in;
   logic [20:0] wsec_in;
   logic [28:0] prod_in;

   logic                 s1_valid_ff;
   op_type               op_ff;
   logic [11:0]          yy_ff;
   logic [8:0]           term_ff;
   logic [8:0]           dd_ff;
   logic                 carry_ff;
   logic [16:0]          sec_ff;
   logic [21:0]          jin_ff;
   logic [13:0]          wk_ff;
   logic [20:0]          wsec_ff;
   logic [28:0]          prod_ff;
   logic [FRAC_BITS-1:0] frac1_ff;

   logic [4:0]  q_day;
   logic [22:0] jd_in;
   logic [16:0] ds_in;

   logic                 s2_valid_ff;
   logic [22:0]          jd_ff;
   logic [16:0]          ds_ff;
   logic [FRAC_BITS-1:0] frac2_ff;

   // Widen the year, fold January and February, sum the time of day
   always_comb begin
      wide_year = year;
      if (year < 12'd1900) begin
         wide_year = (year < 12'd80) ? year + 12'd2000 : year + 12'd1900;
      end
      if (op == OP_DAY_OF_YEAR) begin
         yy_in = wide_year - 12'd1;
         idx   = 5'd14;
      end else if (month <= 4'd2) begin
         yy_in = wide_year - 12'd1;
         idx   = {1'b0, month} + 5'd13;
      end else begin
         yy_in = wide_year;
         idx   = {1'b0, month} + 5'd1;
      end
      tod = 18'(hour) * 18'd3600 + 18'(minute) * 18'd60 + 18'(whole_second)
            + 18'(HALF_DAY);
      tod_sub = tod - 18'(SEC_PER_DAY);
      if (op == OP_JULIAN) begin
         carry_in = (day_seconds >= SEC_PER_DAY);
         sec_in   = carry_in ? day_seconds - SEC_PER_DAY : day_seconds;
      end else begin
         carry_in = (tod >= 18'(SEC_PER_DAY));
         sec_in   = carry_in ? tod_sub[16:0] : tod[16:0];
      end
      wsec_in = 21'(week_second) + 21'(HALF_DAY);
      prod_in = 29'(wsec_in[20:7]) * 29'(RECIP_675);
   end

   // Stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      op_ff    <= op;
      yy_ff    <= yy_in;
      term_ff  <= MONTH_TERM[idx];
      dd_ff    <= day_number;
      carry_ff <= carry_in;
      sec_ff   <= sec_in;
      jin_ff   <= julian_day;
      wk_ff    <= gps_week;
      wsec_ff  <= wsec_in;
      prod_ff  <= prod_in;
      frac1_ff <= second_fraction;
   end

   // Form the Julian day and seconds since noon
   always_comb begin
      q_day = prod_ff[28:24];
      jd_in = '0;
      ds_in = sec_ff;
      case (op_ff)
         OP_CIVIL, OP_DAY_OF_YEAR: begin
            jd_in = 23'((25'(yy_ff) * 25'd1461) >> 2) + 23'(term_ff) + 23'(dd_ff)
                    + CAL_OFFSET + 23'(carry_ff);
         end
         OP_JULIAN: begin
            jd_in = 23'(jin_ff) + 23'(carry_ff);
         end
         OP_GPS_WEEK: begin
            jd_in = GPS_EPOCH_DAY + 23'(wk_ff) * 23'd7 + 23'(q_day);
            ds_in = 17'(wsec_ff - 21'(q_day) * 21'd86400);
         end
         default: begin
            jd_in = '0;
         end
      endcase
   end

   // Stage 2 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      jd_ff    <= jd_in;
      ds_ff    <= ds_in;
      frac2_ff <= frac1_ff;
   end

   assign out_valid = s2_valid_ff;
   assign out_jd    = jd_ff;
   assign out_ds    = ds_ff;
   assign out_frac  = frac2_ff;

endmodule

// ===== rtl/cjgt_back.sv =====
// Back end: derive civil date, clock time and GPS week from Julian day.
module cjgt_back #(
   parameter int FRAC_BITS = cjgt_pkg::FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [22:0]                    in_jd,
   input  logic [16:0]                    in_ds,
   input  logic [FRAC_BITS-1:0]           in_frac,
   output logic                           out_valid,
   output cjgt_pkg::result_type           out_result,
   output logic [FRAC_BITS-1:0]           out_frac
);
   import cjgt_pkg::*;

   // Stage 3
   logic [22:0] a_in, b_in, p_in;
   logic [28:0] n_in;
   logic [16:0] u_in;
   logic                 v3_ff;
   logic [22:0]          a3_ff, b3_ff, p3_ff, jd3_ff;
   logic [28:0]          n3_ff;
   logic [16:0]          u3_ff, ds3_ff;
   logic [FRAC_BITS-1:0] f3_ff;

   // Stage 4
   logic [58:0] c_prod;
   logic [46:0] q7_prod;
   logic [34:0] m60_prod;
   logic                 v4_ff;
   logic [13:0]          c4_ff;
   logic [19:0]          q74_ff;
   logic [10:0]          m604_ff;
   logic [22:0]          a4_ff, b4_ff, p4_ff, jd4_ff;
   logic [16:0]          u4_ff, ds4_ff;
   logic [FRAC_BITS-1:0] f4_ff;

   // Stage 5
   logic [24:0] d_full;
   logic [22:0] v_full;
   logic [22:0] wr_full;
   logic [19:0] tow_in;
   logic [22:0] hr_prod;
   logic [16:0] sec_full;
   logic                 v5_ff;
   logic [8:0]           v5v_ff;
   logic [13:0]          c5_ff;
   logic [19:0]          tow5_ff;
   logic [13:0]          week5_ff;
   logic [4:0]           hr5_ff;
   logic [5:0]           sec5_ff;
   logic [10:0]          m605_ff;
   logic [22:0]          a5_ff, jd5_ff;
   logic [16:0]          ds5_ff;
   logic [FRAC_BITS-1:0] f5_ff;

   // Stage 6
   logic [4:0]         e_cnt;
   logic [8:0]         dom_full;
   logic [4:0]         mon_full;
   logic signed [14:0] yr_in;
   logic [4:0]         hour_in;
   logic [10:0]        min_full;
   logic                 v6_ff;
   result_type           res_ff;
   logic [FRAC_BITS-1:0] f6_ff;

   // Day shifted to midnight, calendar numerator, week numerator
   always_comb begin
      a_in = in_jd + 23'(in_ds >= HALF_DAY);
      b_in = a_in + 23'd1537;
      n_in = 29'(b_in) * 29'd100 - 29'd12210;
      p_in = a_in + WEEK_BIAS;
      u_in = (in_ds >= HALF_DAY) ? in_ds - HALF_DAY : in_ds + HALF_DAY;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= in_valid;
      end
      a3_ff  <= a_in;
      b3_ff  <= b_in;
      p3_ff  <= p_in;
      jd3_ff <= in_jd;
      n3_ff  <= n_in;
      u3_ff  <= u_in;
      ds3_ff <= in_ds;
      f3_ff  <= in_frac;
   end

   // Divide by constants through reciprocal products
   always_comb begin
      c_prod   = 59'(n3_ff) * 59'(RECIP_C);
      q7_prod  = 47'(p3_ff) * 47'(RECIP_7);
      m60_prod = 35'(ds3_ff) * 35'(RECIP_60);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      c4_ff   <= c_prod[58:45];
      q74_ff  <= q7_prod[45:26];
      m604_ff <= m60_prod[33:23];
      a4_ff   <= a3_ff;
      b4_ff   <= b3_ff;
      p4_ff   <= p3_ff;
      jd4_ff  <= jd3_ff;
      u4_ff   <= u3_ff;
      ds4_ff  <= ds3_ff;
      f4_ff   <= f3_ff;
   end

   // Day within the March-based year, seconds of week, hours
   always_comb begin
      d_full   = (25'(c4_ff) * 25'd1461) >> 2;
      v_full   = b4_ff - d_full[22:0];
      wr_full  = p4_ff - 23'(q74_ff) * 23'd7;
      tow_in   = 20'(wr_full[2:0]) * 20'd86400 + 20'(u4_ff);
      hr_prod  = 23'(m604_ff) * 23'(RECIP_60S);
      sec_full = ds4_ff - 17'(m604_ff) * 17'd60;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      v5v_ff   <= v_full[8:0];
      c5_ff    <= c4_ff;
      tow5_ff  <= tow_in;
      week5_ff <= q74_ff[13:0];
      hr5_ff   <= hr_prod[21:17];
      sec5_ff  <= sec_full[5:0];
      m605_ff  <= m604_ff;
      a5_ff    <= a4_ff;
      jd5_ff   <= jd4_ff;
      ds5_ff   <= ds4_ff;
      f5_ff    <= f4_ff;
   end

   // Month, day of month, year, clock hour and minute
   always_comb begin
      e_cnt = '0;
      for (int k = 1; k < 17; k++) begin
         if (v5v_ff >= MONTH_LIMIT[k]) begin
            e_cnt = e_cnt + 5'd1;
         end
      end
      dom_full = v5v_ff - MONTH_TERM[e_cnt];
      mon_full = (e_cnt >= 5'd14) ? e_cnt - 5'd13 : e_cnt - 5'd1;
      yr_in    = $signed({1'b0, c5_ff}) - 15'sd4715
                 - ((mon_full >= 5'd3) ? 15'sd1 : 15'sd0);
      hour_in  = (hr5_ff >= 5'd12) ? hr5_ff - 5'd12 : hr5_ff + 5'd12;
      min_full = m605_ff - 11'(hr5_ff) * 11'd60;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      res_ff.month        <= mon_full[3:0];
      res_ff.day_of_month <= dom_full[4:0];
      res_ff.hour         <= hour_in;
      res_ff.minute       <= min_full[5:0];
      res_ff.second       <= sec5_ff;
      res_ff.julian_day   <= jd5_ff;
      res_ff.day_seconds  <= ds5_ff;
      res_ff.gps_week     <= week5_ff;
      res_ff.week_second  <= tow5_ff;
      res_ff.civil_year   <= yr_in;
      res_ff.day_a        <= a5_ff;
      f6_ff               <= f5_ff;
   end

   assign out_valid  = v6_ff;
   assign out_result = res_ff;
   assign out_frac   = f6_ff;

endmodule

// ===== rtl/civil_julian_gps_time_converter.sv =====
// Top level: timestamp converter between civil, Julian, GPS week and day-of-year forms.
//
//   channel   ports              handshake
//   request   start, req_*       taken when start is high and busy is low
//   response  rsp_valid, rsp_*   one-cycle strobe, always taken
//
// A word passes seven register stages (two front, four back, one output)
// before its rsp_valid strobe rises. One word may enter every cycle; the
// constant divides are reciprocal products spread over the stages. busy stays
// low. Reset clears only the valid bits of the pipeline; words in flight are
// dropped. The receiver cannot stall.
module civil_julian_gps_time_converter #(
   parameter int FRAC_BITS = cjgt_pkg::FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  cjgt_pkg::op_type               req_operation,
   input  logic [11:0]                    req_year,
   input  logic [3:0]                     req_month,
   input  logic [8:0]                     req_day_number,
   input  logic [4:0]                     req_hour,
   input  logic [5:0]                     req_minute,
   input  logic [5:0]                     req_whole_second,
   input  logic [FRAC_BITS-1:0]           req_second_fraction,
   input  logic [21:0]                    req_julian_day,
   input  logic [16:0]                    req_day_seconds,
   input  logic [13:0]                    req_gps_week,
   input  logic [19:0]                    req_week_second,
   output logic                           rsp_valid,
   output logic [11:0]                    rsp_out_year,
   output logic [3:0]                     rsp_out_month,
   output logic [4:0]                     rsp_out_day_of_month,
   output logic [4:0]                     rsp_out_hour,
   output logic [5:0]                     rsp_out_minute,
   output logic [5:0]                     rsp_out_whole_second,
   output logic [FRAC_BITS-1:0]           rsp_out_second_fraction,
   output logic [21:0]                    rsp_out_julian_day,
   output logic [16:0]                    rsp_out_day_seconds,
   output logic [13:0]                    rsp_out_gps_week,
   output logic [19:0]                    rsp_out_week_second,
   output logic [8:0]                     rsp_out_day_of_year
);
   import cjgt_pkg::*;

   logic                 accept;
   logic                 fe_valid;
   logic [22:0]          fe_jd;
   logic [16:0]          fe_ds;
   logic [FRAC_BITS-1:0] fe_frac;
   logic                 be_valid;
   result_type           be_res;
   logic [FRAC_BITS-1:0] be_frac;

   logic signed [14:0] yr_m1;
   logic signed [26:0] year_days;
   logic signed [26:0] doy_full;

   logic                 valid_ff;
   result_type           res_ff;
   logic [FRAC_BITS-1:0] frac_ff;
   logic [8:0]           doy_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;

   cjgt_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (accept),
      .op              (req_operation),
      .year            (req_year),
      .month           (req_month),
      .day_number      (req_day_number),
      .hour            (req_hour),
      .minute          (req_minute),
      .whole_second    (req_whole_second),
      .second_fraction (req_second_fraction),
      .julian_day      (req_julian_day),
      .day_seconds     (req_day_seconds),
      .gps_week        (req_gps_week),
      .week_second     (req_week_second),
      .out_valid       (fe_valid),
      .out_jd          (fe_jd),
      .out_ds          (fe_ds),
      .out_frac        (fe_frac)
   );

   cjgt_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (fe_valid),
      .in_jd      (fe_jd),
      .in_ds      (fe_ds),
      .in_frac    (fe_frac),
      .out_valid  (be_valid),
      .out_result (be_res),
      .out_frac   (be_frac)
   );

   // Day of year from January 1 of the derived year
   always_comb begin
      yr_m1     = be_res.civil_year - 15'sd1;
      year_days = ($signed({{12{yr_m1[14]}}, yr_m1}) * 27'sd1461) >>> 2;
      doy_full  = $signed({4'b0000, be_res.day_a}) - year_days
                  - $signed(JAN_FIRST_OFFSET);
   end

   // Output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= be_valid;
      end
      res_ff  <= be_res;
      frac_ff <= be_frac;
      doy_ff  <= doy_full[8:0];
   end

   assign rsp_valid               = valid_ff;
   assign rsp_out_year            = res_ff.civil_year[11:0];
   assign rsp_out_month           = res_ff.month;
   assign rsp_out_day_of_month    = res_ff.day_of_month;
   assign rsp_out_hour            = res_ff.hour;
   assign rsp_out_minute          = res_ff.minute;
   assign rsp_out_whole_second    = res_ff.second;
   assign rsp_out_second_fraction = frac_ff;
   assign rsp_out_julian_day      = res_ff.julian_day[21:0];
   assign rsp_out_day_seconds     = res_ff.day_seconds;
   assign rsp_out_gps_week        = res_ff.gps_week;
   assign rsp_out_week_second     = res_ff.week_second;
   assign rsp_out_day_of_year     = doy_ff;

endmodule

// ===== test/tb_civil_julian_gps_time_converter.sv =====
// Self-checking testbench for the civil/Julian/GPS time converter.
module tb_civil_julian_gps_time_converter;
   timeunit 1ns;
   timeprecision 1ps;
   import cjgt_pkg::*;

   typedef struct {
      op_type      operation;
      logic [11:0] year;
      logic [3:0]  month;
      logic [8:0]  day_number;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  whole_second;
      logic [19:0] second_fraction;
      logic [21:0] julian_day;
      logic [16:0] day_seconds;
      logic [13:0] gps_week;
      logic [19:0] week_second;
   } stamp_in_type;

   typedef struct {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  whole_second;
      logic [19:0] second_fraction;
      logic [21:0] julian_day;
      logic [16:0] day_seconds;
      logic [13:0] gps_week;
      logic [19:0] week_second;
      logic [8:0]  day_of_year;
   } stamp_out_type;

   // Floor division and nonnegative remainder on signed 64-bit values
   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q = q - 1;
      return q;
   endfunction

   function automatic longint floor_mod(longint a, longint b);
      return a - floor_div(a, b) * b;
   endfunction

   // Noon-based day number holding civil midnight of y/m/d
   function automatic longint day_base(longint y, longint m, longint d);
      if (m <= 2) begin
         y = y - 1;
         m = m + 12;
      end
      return floor_div(1461 * y, 4) + floor_div(306001 * (m + 1), 10000) + d + 1720981;
   endfunction

   // Convert one timestamp into all four forms
   function automatic stamp_out_type convert_stamp(stamp_in_type s);
      stamp_out_type r;
      longint y, jd, ds, tod, t, a, b, c, d, e, dom, mon, yr;
      if (s.operation == OP_CIVIL || s.operation == OP_DAY_OF_YEAR) begin
         y = s.year;
         if (y < 1900) y = y + ((y < 80) ? 2000 : 1900);
         tod = longint'(s.hour) * 3600 + longint'(s.minute) * 60 + s.whole_second + 43200;
         if (s.operation == OP_CIVIL) jd = day_base(y, s.month, s.day_number);
         else jd = day_base(y, 1, 1) + s.day_number - 1;
         jd = jd + floor_div(tod, 86400);
         ds = floor_mod(tod, 86400);
      end else if (s.operation == OP_JULIAN) begin
         jd = longint'(s.julian_day) + s.day_seconds / 86400;
         ds = s.day_seconds % 86400;
      end else begin
         t = longint'(s.gps_week) * 604800 + s.week_second + 43200;
         jd = 2444244 + floor_div(t, 86400);
         ds = floor_mod(t, 86400);
      end
      a = jd + ((ds >= 43200) ? 1 : 0);
      b = a + 1537;
      c = floor_div(100 * b - 12210, 36525);
      d = floor_div(1461 * c, 4);
      e = floor_div((b - d) * 10000, 306001);
      dom = b - d - floor_div(306001 * e, 10000);
      mon = e - 1 - 12 * floor_div(e, 14);
      yr = c - 4715 - floor_div(7 + mon, 10);
      t = (jd - 2444244) * 86400 + ds - 43200;
      r.year = yr[11:0];
      r.month = mon[3:0];
      r.day_of_month = dom[4:0];
      r.hour = 5'((ds / 3600 + 12) % 24);
      r.minute = 6'((ds % 3600) / 60);
      r.whole_second = 6'(ds % 60);
      r.second_fraction = s.second_fraction;
      r.julian_day = jd[21:0];
      r.day_seconds = ds[16:0];
      r.gps_week = 14'(floor_div(t, 604800));
      r.week_second = 20'(floor_mod(t, 604800));
      r.day_of_year = 9'(a - day_base(yr, 1, 1));
      return r;
   endfunction

   // Holds pending conversions and compares returned words against them
   class stamp_scoreboard;
      stamp_out_type pending[$];
      int errors = 0;

      function void note_input(stamp_in_type s);
         pending.push_back(convert_stamp(s));
      endfunction

      function void field(string name, longint e, longint g);
         if (e != g) begin
            $error("%s expected %0d actual %0d", name, e, g);
            errors++;
         end
      endfunction

      function void check_result(stamp_out_type g);
         stamp_out_type e;
         if (pending.size() == 0) begin
            $error("result word with nothing pending");
            errors++;
            return;
         end
         e = pending.pop_front();
         field("out_year", e.year, g.year);
         field("out_month", e.month, g.month);
         field("out_day_of_month", e.day_of_month, g.day_of_month);
         field("out_hour", e.hour, g.hour);
         field("out_minute", e.minute, g.minute);
         field("out_whole_second", e.whole_second, g.whole_second);
         field("out_second_fraction", e.second_fraction, g.second_fraction);
         field("out_julian_day", e.julian_day, g.julian_day);
         field("out_day_seconds", e.day_seconds, g.day_seconds);
         field("out_gps_week", e.gps_week, g.gps_week);
         field("out_week_second", e.week_second, g.week_second);
         field("out_day_of_year", e.day_of_year, g.day_of_year);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   stamp_in_type req = '{OP_CIVIL, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0};
   stamp_out_type rsp;
   logic rsp_valid;
   stamp_scoreboard board = new();
   int idle_cycles = 0;

   always #2 clock = ~clock;

   civil_julian_gps_time_converter uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req.operation), .req_year(req.year), .req_month(req.month),
      .req_day_number(req.day_number), .req_hour(req.hour), .req_minute(req.minute),
      .req_whole_second(req.whole_second), .req_second_fraction(req.second_fraction),
      .req_julian_day(req.julian_day), .req_day_seconds(req.day_seconds),
      .req_gps_week(req.gps_week), .req_week_second(req.week_second),
      .rsp_valid(rsp_valid), .rsp_out_year(rsp.year), .rsp_out_month(rsp.month),
      .rsp_out_day_of_month(rsp.day_of_month), .rsp_out_hour(rsp.hour),
      .rsp_out_minute(rsp.minute), .rsp_out_whole_second(rsp.whole_second),
      .rsp_out_second_fraction(rsp.second_fraction), .rsp_out_julian_day(rsp.julian_day),
      .rsp_out_day_seconds(rsp.day_seconds), .rsp_out_gps_week(rsp.gps_week),
      .rsp_out_week_second(rsp.week_second), .rsp_out_day_of_year(rsp.day_of_year)
   );

   // Check result words and count cycles with no traffic
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) board.check_result(rsp);
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 2000) begin
            $display("[civil_julian_gps_time_converter] ERROR");
            $finish;
         end
      end
   end

   // Present one word, hold until taken, then pause for the given gap
   task automatic send_word(stamp_in_type s, int gap);
      req <= s;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_input(s);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic int draw_gap(bit burst);
      if (burst) return 0;
      return $urandom_range(0, 14);
   endfunction

   // Random word: mostly in-range fields, sometimes raw bits
   function automatic stamp_in_type random_word();
      stamp_in_type s;
      bit wild;
      wild = ($urandom_range(0, 7) == 0);
      s.operation = op_type'($urandom_range(0, 3));
      s.year = wild ? 12'($urandom) :
               ($urandom_range(0, 2) == 0 ? 12'($urandom_range(0, 99))
                                           : 12'($urandom_range(1900, 2099)));
      s.month = wild ? 4'($urandom) : 4'($urandom_range(1, 12));
      s.day_number = wild ? 9'($urandom) :
                     (s.operation == OP_DAY_OF_YEAR ? 9'($urandom_range(1, 366))
                                                    : 9'($urandom_range(1, 31)));
      s.hour = wild ? 5'($urandom) : 5'($urandom_range(0, 23));
      s.minute = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
      s.whole_second = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
      s.second_fraction = 20'($urandom);
      s.julian_day = wild ? 22'($urandom) : 22'($urandom_range(2415021, 2488069));
      s.day_seconds = wild ? 17'($urandom) : 17'($urandom_range(0, 86399));
      s.gps_week = wild ? 14'($urandom) : 14'($urandom_range(0, 6200));
      s.week_second = wild ? 20'($urandom) : 20'($urandom_range(0, 604799));
      return s;
   endfunction

   initial begin
      stamp_in_type s;
      bit burst;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, each form, two-digit years, overflows, leap days
      s = '{OP_CIVIL, 12'd1980, 4'd1, 9'd6, 5'd0, 6'd0, 6'd0, 20'd0, 22'd0, 17'd0, 14'd0, 20'd0};
      send_word(s, 0);
      s.year = 12'd79; s.month = 4'd2; s.day_number = 9'd29; s.second_fraction = '1;
      send_word(s, 1);
      s.year = 12'd80; s.month = 4'd12; s.day_number = 9'd31;
      s.hour = 5'd23; s.minute = 6'd59; s.whole_second = 6'd59;
      send_word(s, 0);
      s.year = 12'd4095; s.month = 4'd15; s.day_number = 9'd511;
      s.hour = 5'd31; s.minute = 6'd63; s.whole_second = 6'd63;
      send_word(s, 2);
      s.year = 12'd1900; s.month = 4'd0; s.day_number = 9'd0;
      send_word(s, 0);
      s.operation = OP_DAY_OF_YEAR; s.year = 12'd2000; s.day_number = 9'd366;
      s.hour = 5'd12; s.minute = 6'd0; s.whole_second = 6'd0;
      send_word(s, 0);
      s.day_number = 9'd0; s.year = 12'd0;
      send_word(s, 0);
      s.day_number = 9'd511; s.year = 12'd2099;
      send_word(s, 3);
      s.operation = OP_JULIAN; s.julian_day = 22'd2451545; s.day_seconds = 17'd0;
      send_word(s, 0);
      s.day_seconds = 17'd86399;
      send_word(s, 0);
      s.day_seconds = 17'h1FFFF; s.julian_day = '1;
      send_word(s, 0);
      s.julian_day = 22'd0; s.day_seconds = 17'd43200;
      send_word(s, 0);
      s.operation = OP_GPS_WEEK; s.gps_week = 14'd0; s.week_second = 20'd0;
      send_word(s, 0);
      s.week_second = 20'd604799;
      send_word(s, 0);
      s.gps_week = '1; s.week_second = '1;
      send_word(s, 0);
      s.gps_week = 14'd2048; s.week_second = 20'd345600;
      send_word(s, 1);
      s.operation = OP_JULIAN; s.julian_day = 22'd2444000; s.day_seconds = 17'd100;
      send_word(s, 0);

      // Hold off until the pipeline drains
      start <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);

      // Random: bursts without gaps mix with random gaps, chosen per block of 100 words
      burst = 1'b0;
      for (int i = 0; i < 1100; i++) begin
         if (i % 100 == 0) burst = ($urandom_range(0, 2) == 0);
         send_word(random_word(), draw_gap(burst));
      end
      start <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0)
         $display("[civil_julian_gps_time_converter] OK");
      else
         $display("[civil_julian_gps_time_converter] ERROR");
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/cjgt_pkg.sv
rtl/cjgt_front.sv
rtl/cjgt_back.sv
rtl/civil_julian_gps_time_converter.sv
test/tb_civil_julian_gps_time_converter.sv
